// ===== rtl/paa_pkg.sv =====
package paa_pkg;

   localparam int NUM_SOURCES        = 19;
   localparam int REQ_BITS           = 19;
   localparam int SRC_W              = $clog2(NUM_SOURCES);
   localparam int IDX_W              = 5;
   localparam int FRAME_W            = 32;
   localparam int NEXT_W             = FRAME_W + 1;
   localparam int PRI_W              = 16;
   localparam int TIME_W             = 20;
   localparam int FIRST_ACTIVE_FRAME = 2;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_SELECT,
      S_COMMIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic               we;
      logic [SRC_W-1:0]   index;
      logic               defined;
      logic [PRI_W-1:0]   prio;
      logic [TIME_W-1:0]  cooldown;
      logic [TIME_W-1:0]  expire;
   } set_wr_type;

   typedef struct packed {
      logic               live_we;
      logic               live;
      logic               played_we;
      logic               played;
      logic               trig_we;
      logic [FRAME_W-1:0] trig;
      logic               nxt_we;
      logic [NEXT_W-1:0]  nxt;
   } ent_wr_type;

   typedef struct packed {
      logic               defined;
      logic               live;
      logic               played;
      logic [PRI_W-1:0]   prio;
      logic [TIME_W-1:0]  cooldown;
      logic [TIME_W-1:0]  expire;
      logic [FRAME_W-1:0] trig;
      logic [NEXT_W-1:0]  nxt;
   } ent_rd_type;

endpackage

// ===== rtl/paa_if.sv =====
interface paa_req_if import paa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [FRAME_W-1:0] frame;
   logic [REQ_BITS-1:0] request_mask;
   logic               enabled;
   logic               player_present;
   logic               output_busy;
   logic [IDX_W-1:0]   entry_index;
   logic               entry_defined;
   logic [PRI_W-1:0]   entry_priority;
   logic [TIME_W-1:0]  entry_cooldown;
   logic [TIME_W-1:0]  entry_expire;

   modport source (
      output valid, mode, frame, request_mask, enabled, player_present, output_busy,
             entry_index, entry_defined, entry_priority, entry_cooldown, entry_expire,
      input  ready
   );
   modport sink (
      input  valid, mode, frame, request_mask, enabled, player_present, output_busy,
             entry_index, entry_defined, entry_priority, entry_cooldown, entry_expire,
      output ready
   );
endinterface

interface paa_rsp_if import paa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             announce_valid;
   logic [IDX_W-1:0] announce_source;

   modport source (output valid, announce_valid, announce_source, input ready);
   modport sink (input valid, announce_valid, announce_source, output ready);
endinterface

// ===== rtl/paa_table.sv =====
module paa_table import paa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  set_wr_type       set_wr,
   input  logic [SRC_W-1:0] ent_idx,
   input  ent_wr_type       ent_wr,
   output ent_rd_type       ent_rd
);

   logic [NUM_SOURCES-1:0] defined_ff;
   logic [NUM_SOURCES-1:0] live_ff;
   logic [NUM_SOURCES-1:0] played_ff;
   logic [PRI_W-1:0]       prio_ff     [NUM_SOURCES];
   logic [TIME_W-1:0]      cooldown_ff [NUM_SOURCES];
   logic [TIME_W-1:0]      expire_ff   [NUM_SOURCES];
   logic [FRAME_W-1:0]     trig_ff     [NUM_SOURCES];
   logic [NEXT_W-1:0]      nxt_ff      [NUM_SOURCES];

   always_ff @(posedge clock) begin
      if (reset) begin
         defined_ff <= '0;
         live_ff    <= '0;
         played_ff  <= '0;
      end else begin
         if (set_wr.we) begin
            defined_ff[set_wr.index] <= set_wr.defined;
         end
         if (ent_wr.live_we) begin
            live_ff[ent_idx] <= ent_wr.live;
         end
         if (ent_wr.played_we) begin
            played_ff[ent_idx] <= ent_wr.played;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (set_wr.we) begin
         prio_ff[set_wr.index]     <= set_wr.prio;
         cooldown_ff[set_wr.index] <= set_wr.cooldown;
         expire_ff[set_wr.index]   <= set_wr.expire;
      end
      if (ent_wr.trig_we) begin
         trig_ff[ent_idx] <= ent_wr.trig;
      end
      if (ent_wr.nxt_we) begin
         nxt_ff[ent_idx] <= ent_wr.nxt;
      end
   end

   always_comb begin
      ent_rd.defined  = defined_ff[ent_idx];
      ent_rd.live     = live_ff[ent_idx];
      ent_rd.played   = played_ff[ent_idx];
      ent_rd.prio     = prio_ff[ent_idx];
      ent_rd.cooldown = cooldown_ff[ent_idx];
      ent_rd.expire   = expire_ff[ent_idx];
      ent_rd.trig     = trig_ff[ent_idx];
      ent_rd.nxt      = nxt_ff[ent_idx];
   end

endmodule

// ===== rtl/paa_unit.sv =====
module paa_unit import paa_pkg::*; (
   input  logic [NEXT_W-1:0] add_a,
   input  logic [TIME_W-1:0] add_b,
   input  logic [NEXT_W-1:0] cmp_rhs,
   output logic [NEXT_W-1:0] sum,
   output logic              sum_le
);

   // Operands never exceed 2^32 + 2^20, so the sum cannot wrap.
   assign sum    = add_a + NEXT_W'(add_b);
   assign sum_le = (sum <= cmp_rhs);

endmodule

// ===== rtl/prioritized_alert_arbiter_core.sv =====
// Channel   Port      Dir  Accepted when         Payload
// request   req_chan  in   valid && ready        mode, frame, request_mask, flags, entry fields
// result    rsp_chan  out  valid && ready        announce_valid, announce_source
//
// A load, a disabled tick or an early-frame tick goes from IDLE straight to DONE, which
// registers the result. A full tick gives each source an update step through the one
// shared adder/comparator and a select step, then one commit step for the winner. One
// item at a time; ready is high only when idle, and a waiting result does not block
// the next accept, only the next result.
// Reset clears the defined, live and played bits and the held requests.
module prioritized_alert_arbiter_core import paa_pkg::*; (
   input logic   clock,
   input logic   reset,
   paa_req_if.sink   req_chan,
   paa_rsp_if.source rsp_chan
);

   state_type state_ff, state_in;

   logic [SRC_W-1:0]    idx_ff, idx_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic [NEXT_W-1:0]   frame_p1_ff, frame_p1_in;
   logic [REQ_BITS-1:0] reqs_ff, reqs_in;
   logic [REQ_BITS-1:0] held_ff, held_in;
   logic                player_ff, player_in;
   logic                busy_ff, busy_in;
   logic                win_valid_ff, win_valid_in;
   logic [SRC_W-1:0]    win_idx_ff, win_idx_in;
   logic [PRI_W-1:0]    win_pri_ff, win_pri_in;
   logic [FRAME_W-1:0]  win_trig_ff, win_trig_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ann_ff, rsp_ann_in;
   logic [IDX_W-1:0]    rsp_src_ff, rsp_src_in;

   set_wr_type set_wr;
   ent_wr_type ent_wr;
   ent_rd_type ent_rd;

   logic [NEXT_W-1:0]      unit_a;
   logic [TIME_W-1:0]      unit_b;
   logic [NEXT_W-1:0]      unit_rhs;
   logic [NEXT_W-1:0]      unit_sum;
   logic                   unit_le;
   logic [NUM_SOURCES-1:0] req_ext;

   logic accept;
   logic tick_go;
   logic last_idx;
   logic rsp_free;
   logic create;
   logic cand;
   logic better;

   paa_table u_table (
      .clock   (clock),
      .reset   (reset),
      .set_wr  (set_wr),
      .ent_idx (idx_ff),
      .ent_wr  (ent_wr),
      .ent_rd  (ent_rd)
   );

   paa_unit u_unit (
      .add_a   (unit_a),
      .add_b   (unit_b),
      .cmp_rhs (unit_rhs),
      .sum     (unit_sum),
      .sum_le  (unit_le)
   );

   assign accept   = req_chan.valid && req_chan.ready;
   assign tick_go  = (req_chan.mode == MODE_TICK) && req_chan.enabled &&
                     (req_chan.frame >= FRAME_W'(FIRST_ACTIVE_FRAME));
   assign last_idx = (idx_ff == SRC_W'(NUM_SOURCES - 1));
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_ext  = NUM_SOURCES'(reqs_ff);
   assign create   = player_ff && ent_rd.defined && !ent_rd.live && req_ext[idx_ff];
   assign cand     = !busy_ff && ent_rd.live && !ent_rd.played && (ent_rd.prio != '0);
   assign better   = !win_valid_ff || (ent_rd.prio > win_pri_ff) ||
                     ((ent_rd.prio == win_pri_ff) && (ent_rd.trig < win_trig_ff));

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.announce_valid  = rsp_ann_ff;
   assign rsp_chan.announce_source = rsp_src_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = tick_go ? S_UPDATE : S_DONE;
            end
         end
         S_UPDATE: state_in = S_SELECT;
         S_SELECT: state_in = last_idx ? S_COMMIT : S_UPDATE;
         S_COMMIT: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake, table writes, shared unit operands
   always_comb begin
      req_chan.ready  = 1'b0;
      set_wr          = '0;
      ent_wr          = '0;
      unit_a          = '0;
      unit_b          = '0;
      unit_rhs        = '0;
      set_wr.index    = SRC_W'(req_chan.entry_index);
      set_wr.defined  = req_chan.entry_defined;
      set_wr.prio     = req_chan.entry_priority;
      set_wr.cooldown = req_chan.entry_cooldown;
      set_wr.expire   = req_chan.entry_expire;
      case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            set_wr.we = accept && (req_chan.mode == MODE_LOAD) &&
                        (int'(req_chan.entry_index) < NUM_SOURCES);
         end
         S_UPDATE: begin
            if (create) begin
               // new entry expires at once only when its expiry is zero
               unit_a           = {1'b0, frame_ff};
               unit_b           = ent_rd.cooldown;
               ent_wr.live_we   = 1'b1;
               ent_wr.live      = (ent_rd.expire != '0);
               ent_wr.played_we = 1'b1;
               ent_wr.played    = 1'b0;
               ent_wr.trig_we   = 1'b1;
               ent_wr.trig      = frame_ff;
               ent_wr.nxt_we    = 1'b1;
               ent_wr.nxt       = unit_sum;
            end else if (ent_rd.live) begin
               if (ent_rd.played) begin
                  unit_a   = ent_rd.nxt;
                  unit_rhs = frame_p1_ff;
               end else begin
                  unit_a   = {1'b0, ent_rd.trig};
                  unit_b   = ent_rd.expire;
                  unit_rhs = {1'b0, frame_ff};
               end
               ent_wr.live_we = unit_le;
               ent_wr.live    = 1'b0;
            end
         end
         S_COMMIT: begin
            if (win_valid_ff) begin
               unit_a           = {1'b0, frame_ff};
               unit_b           = ent_rd.cooldown;
               ent_wr.played_we = 1'b1;
               ent_wr.played    = 1'b1;
               ent_wr.nxt_we    = 1'b1;
               ent_wr.nxt       = unit_sum;
            end
         end
         default: begin
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      idx_in       = idx_ff;
      frame_in     = frame_ff;
      frame_p1_in  = frame_p1_ff;
      reqs_in      = reqs_ff;
      held_in      = held_ff;
      player_in    = player_ff;
      busy_in      = busy_ff;
      win_valid_in = win_valid_ff;
      win_idx_in   = win_idx_ff;
      win_pri_in   = win_pri_ff;
      win_trig_in  = win_trig_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_ann_in   = rsp_ann_ff;
      rsp_src_in   = rsp_src_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               frame_in     = req_chan.frame;
               frame_p1_in  = {1'b0, req_chan.frame} + NEXT_W'(1);
               player_in    = req_chan.player_present;
               busy_in      = req_chan.output_busy;
               win_valid_in = 1'b0;
               win_idx_in   = '0;
               idx_in       = '0;
               if (req_chan.mode == MODE_TICK) begin
                  if (!req_chan.enabled) begin
                     held_in = '0;
                  end else if (!tick_go) begin
                     // early frame: hold requests for the first active tick
                     held_in = held_ff | req_chan.request_mask;
                  end else begin
                     reqs_in = held_ff | req_chan.request_mask;
                     held_in = '0;
                  end
               end
            end
         end
         S_SELECT: begin
            if (cand && better) begin
               win_valid_in = 1'b1;
               win_idx_in   = idx_ff;
               win_pri_in   = ent_rd.prio;
               win_trig_in  = ent_rd.trig;
            end
            // point at the winner for the commit step
            idx_in = last_idx ? win_idx_in : idx_ff + SRC_W'(1);
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ann_in   = win_valid_ff;
               rsp_src_in   = win_valid_ff ? IDX_W'(win_idx_ff) : '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         win_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         win_valid_ff <= win_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      frame_ff    <= frame_in;
      frame_p1_ff <= frame_p1_in;
      reqs_ff     <= reqs_in;
      player_ff   <= player_in;
      busy_ff     <= busy_in;
      win_idx_ff  <= win_idx_in;
      win_pri_ff  <= win_pri_in;
      win_trig_ff <= win_trig_in;
      rsp_ann_ff  <= rsp_ann_in;
      rsp_src_ff  <= rsp_src_in;
   end

`ifndef SYNTH
   a_win_needs_idle_output: assert property (@(posedge clock) disable iff (reset)
      win_valid_ff |-> !busy_ff)
      else $error("winner chosen while output busy");

   a_commit_entry_waiting: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT) && win_valid_ff |-> ent_rd.live && !ent_rd.played)
      else $error("committed winner is not a waiting entry");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_chan.ready)
      else $error("item accepted during a scan");

   a_quiet_source_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.announce_valid |-> (rsp_chan.announce_source == '0))
      else $error("source index set without an announcement");
`endif

endmodule
